// ===== sv/pcm_stream_linear_resampler_core_assert.svh =====
// Assertion macros used by the resampler datapath.
`ifndef PCM_STREAM_LINEAR_RESAMPLER_CORE_ASSERT_SVH
`define PCM_STREAM_LINEAR_RESAMPLER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define PRSLR_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// Next-cycle implication, disabled while in reset.
`define PRSLR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

// ===== sv/prslr_pkg.sv =====
// ----------------------------------------------------------------------------
// prslr_pkg
// Shared widths, constants and controller/datapath interface types of the
// PCM stream linear resampler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package prslr_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int PHASE_W    = 19;
    localparam int STEP_W     = 18;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 18;
    localparam int MAX_BURST  = 8;
    localparam int CNT_W      = $clog2(MAX_BURST + 1);

    localparam logic [CNT_W-1:0]   BURST_FULL = CNT_W'(MAX_BURST);
    localparam logic [CNT_W-1:0]   BURST_LAST = CNT_W'(MAX_BURST - 1);
    localparam logic [PHASE_W-1:0] PHASE_ONE  = PHASE_W'(32'h10000);

    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEREO      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SIXTEEN_BIT = 2'd2;

    localparam logic [STEP_W-1:0] PHASE_STEP_RST = STEP_W'(32'h10000);

    localparam logic ACTION_DATA    = 1'b0;
    localparam logic ACTION_RESTART = 1'b1;

    // controller -> datapath
    typedef struct packed {
        logic take;     // input transfer this cycle
        logic emit;     // load one output frame, advance phase
        logic finish;   // close the burst: wrap phase, move current to previous
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic frame_emit;    // incoming byte completes a primed frame
        logic phase_ge_one;
        logic burst_full;
        logic out_busy;      // output register holds a frame that is not taken
    } sts_t;

endpackage

// ===== sv/pcm_stream_linear_resampler_core.sv =====
// PCM stream linear resampler. Takes one PCM byte per input transfer, builds
// 1, 2 or 4 byte source frames and emits stereo 16-bit frames interpolated
// between the previous and current source frame, stepping a Q16 phase by
// phase_step. A byte that does not complete a frame, a restart and the
// priming frame are each taken without stalling the input. After a completed
// frame the input is stalled while the controller emits its n output frames
// (up to eight), one per cycle while the output is not stalled, through the
// shared pair of interpolation multipliers, then closes the burst.
// ----------------------------------------------------------------------------
// pcm_stream_linear_resampler_core
// Top level: controller and datapath of the PCM byte stream resampler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pcm_stream_linear_resampler_core (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_wr_en,
    input  logic [prslr_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [prslr_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic                                  action,
    input  logic [7:0]                            data_byte,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [prslr_pkg::SAMPLE_W-1:0] left_sample,
    output logic signed [prslr_pkg::SAMPLE_W-1:0] right_sample,
    output logic                                  last
);

    prslr_pkg::cmd_t cmd;
    prslr_pkg::sts_t sts;

    prslr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    prslr_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .action       (action),
        .data_byte    (data_byte),
        .cmd          (cmd),
        .sts          (sts),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .left_sample  (left_sample),
        .right_sample (right_sample),
        .last         (last)
    );

endmodule

// ===== sv/prslr_ctrl.sv =====
// ----------------------------------------------------------------------------
// prslr_ctrl
// Controller: takes input bytes and sequences the output burst of each
// completed source frame.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module prslr_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  prslr_pkg::sts_t  sts,
    output prslr_pkg::cmd_t  cmd
);

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   in_stall_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.take = in_valid;
                if (in_valid && sts.frame_emit)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (sts.phase_ge_one || sts.burst_full)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
                else if (!sts.out_busy)
                begin
                    cmd.emit = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            in_stall_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            in_stall_reg <= (state_next != ST_IDLE);
        end
    end

    assign in_stall = in_stall_reg;

endmodule

// ===== sv/prslr_datapath.sv =====
// ----------------------------------------------------------------------------
// prslr_datapath
// Datapath: configuration registers, frame assembly, previous/current frame
// registers, phase accumulator, interpolation multipliers and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "pcm_stream_linear_resampler_core_assert.svh"

module prslr_datapath (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_wr_en,
    input  logic [prslr_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [prslr_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                  action,
    input  logic [7:0]                            data_byte,
    input  prslr_pkg::cmd_t                       cmd,
    output prslr_pkg::sts_t                       sts,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [prslr_pkg::SAMPLE_W-1:0] left_sample,
    output logic signed [prslr_pkg::SAMPLE_W-1:0] right_sample,
    output logic                                  last
);

    logic [prslr_pkg::STEP_W-1:0]   phase_step_reg;
    logic                           stereo_reg;
    logic                           sixteen_bit_reg;

    logic [7:0]                     frame_bytes_reg [3];
    logic [1:0]                     byte_count_reg;
    logic                           primed_reg;
    logic [prslr_pkg::PHASE_W-1:0]  phase_acc_reg;
    logic [prslr_pkg::CNT_W-1:0]    burst_cnt_reg;
    logic signed [15:0]             prev_left_reg;
    logic signed [15:0]             prev_right_reg;
    logic signed [15:0]             cur_left_reg;
    logic signed [15:0]             cur_right_reg;

    logic                           out_valid_reg;
    logic signed [15:0]             out_left_reg;
    logic signed [15:0]             out_right_reg;
    logic                           out_last_reg;

    logic [7:0]                     b0, b1, b2, b3;
    logic [1:0]                     size_m1;
    logic                           frame_done;
    logic signed [15:0]             frame_left;
    logic signed [15:0]             frame_right;
    logic signed [16:0]             diff_left;
    logic signed [16:0]             diff_right;
    logic signed [16:0]             weight;
    logic signed [33:0]             prod_left;
    logic signed [33:0]             prod_right;
    logic [prslr_pkg::PHASE_W-1:0]  phase_next;
    logic                           last_next;

    // ---- frame assembly ----
    always_comb
    begin
        b0 = (byte_count_reg == 2'd0) ? data_byte : frame_bytes_reg[0];
        b1 = (byte_count_reg == 2'd1) ? data_byte : frame_bytes_reg[1];
        b2 = (byte_count_reg == 2'd2) ? data_byte : frame_bytes_reg[2];
        b3 = (byte_count_reg == 2'd3) ? data_byte : 8'h00;
        // frame size minus one: 0, 1, 1 or 3 bytes
        size_m1    = {stereo_reg & sixteen_bit_reg, stereo_reg | sixteen_bit_reg};
        frame_done = (byte_count_reg >= size_m1);
        if (sixteen_bit_reg)
        begin
            frame_left  = {b1, b0};
            frame_right = stereo_reg ? {b3, b2} : {b1, b0};
        end
        else
        begin
            // (b - 128) * 256: flip the top bit into the high byte
            frame_left  = {b0 ^ 8'h80, 8'h00};
            frame_right = stereo_reg ? {b1 ^ 8'h80, 8'h00} : {b0 ^ 8'h80, 8'h00};
        end
    end

    // ---- interpolation: prev + floor((cur - prev) * phase / 2^16) ----
    always_comb
    begin
        diff_left  = 17'(cur_left_reg) - 17'(prev_left_reg);
        diff_right = 17'(cur_right_reg) - 17'(prev_right_reg);
        weight     = $signed({1'b0, phase_acc_reg[15:0]});
        prod_left  = 34'(diff_left) * 34'(weight);
        prod_right = 34'(diff_right) * 34'(weight);
        phase_next = phase_acc_reg + prslr_pkg::PHASE_W'(phase_step_reg);
        last_next  = (phase_next[18:16] != 3'd0) || (burst_cnt_reg == prslr_pkg::BURST_LAST);
    end

    always_comb
    begin
        sts.frame_emit   = (action == prslr_pkg::ACTION_DATA) && frame_done && primed_reg;
        sts.phase_ge_one = (phase_acc_reg[18:16] != 3'd0);
        sts.burst_full   = (burst_cnt_reg == prslr_pkg::BURST_FULL);
        sts.out_busy     = out_valid_reg && out_stall;
    end

    // ---- configuration ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_step_reg  <= prslr_pkg::PHASE_STEP_RST;
            stereo_reg      <= 1'b1;
            sixteen_bit_reg <= 1'b1;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                prslr_pkg::CFG_PHASE_STEP:  phase_step_reg  <= cfg_data;
                prslr_pkg::CFG_STEREO:      stereo_reg      <= cfg_data[0];
                prslr_pkg::CFG_SIXTEEN_BIT: sixteen_bit_reg <= cfg_data[0];
                default:                    ;
            endcase
        end
    end

    // ---- stream state ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                frame_bytes_reg[i] <= 8'h00;
            end
            byte_count_reg <= 2'd0;
            primed_reg     <= 1'b0;
            phase_acc_reg  <= '0;
            burst_cnt_reg  <= '0;
            prev_left_reg  <= '0;
            prev_right_reg <= '0;
            cur_left_reg   <= '0;
            cur_right_reg  <= '0;
        end
        else if (cmd.take)
        begin
            if (action == prslr_pkg::ACTION_RESTART)
            begin
                byte_count_reg <= 2'd0;
                primed_reg     <= 1'b0;
                phase_acc_reg  <= '0;
            end
            else if (!frame_done)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    if (byte_count_reg == 2'(i))
                    begin
                        frame_bytes_reg[i] <= data_byte;
                    end
                end
                byte_count_reg <= byte_count_reg + 2'd1;
            end
            else
            begin
                byte_count_reg <= 2'd0;
                if (!primed_reg)
                begin
                    prev_left_reg  <= frame_left;
                    prev_right_reg <= frame_right;
                    primed_reg     <= 1'b1;
                end
                else
                begin
                    cur_left_reg  <= frame_left;
                    cur_right_reg <= frame_right;
                    burst_cnt_reg <= '0;
                end
            end
        end
        else if (cmd.emit)
        begin
            phase_acc_reg <= phase_next;
            burst_cnt_reg <= burst_cnt_reg + prslr_pkg::CNT_W'(1);
        end
        else if (cmd.finish)
        begin
            // wrap once; a burst cut short below 1.0 keeps its phase
            if (sts.phase_ge_one)
            begin
                phase_acc_reg <= phase_acc_reg - prslr_pkg::PHASE_ONE;
            end
            prev_left_reg  <= cur_left_reg;
            prev_right_reg <= cur_right_reg;
        end
    end

    // ---- output register ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_left_reg  <= prev_left_reg + prod_left[31:16];
            out_right_reg <= prev_right_reg + prod_right[31:16];
            out_last_reg  <= last_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign left_sample  = out_left_reg;
    assign right_sample = out_right_reg;
    assign last         = out_last_reg;

    `PRSLR_ASSERT_IMPL(a_burst_bound, clk, rst_n, 1'b1, burst_cnt_reg <= prslr_pkg::BURST_FULL)
    `PRSLR_ASSERT_NEXT(a_last_ends_burst, clk, rst_n, cmd.emit && last_next, sts.phase_ge_one || sts.burst_full)
    `PRSLR_ASSERT_NEXT(a_restart_clears, clk, rst_n, cmd.take && action == prslr_pkg::ACTION_RESTART, !primed_reg && phase_acc_reg == '0 && byte_count_reg == 2'd0)
    `PRSLR_ASSERT_IMPL(a_emit_slot_free, clk, rst_n, cmd.emit, !(out_valid_reg && out_stall) && !sts.phase_ge_one)

endmodule

// ===== sim/pcm_stream_linear_resampler_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcm_stream_linear_resampler_core_tb
// Drives PCM bytes and restarts into the resampler under random valid/stall
// gaps and one long output hold-off. Every output frame is checked field by
// field against a local interpolation predictor or a directed expected
// value. A short directed table covers reset settings, sample extremes, burst
// limits, large steps and a frame size change part way through a frame.
// Random phases with varied register settings follow.
// ----------------------------------------------------------------------------

module pcm_stream_linear_resampler_core_tb;

    localparam int HALF_PERIOD    = 6;
    localparam int RESET_CYCLES   = 12;
    localparam int TARGET_BYTES   = 130;
    localparam int TARGET_FRAMES  = 48;
    localparam int MAX_PHASES     = 60;
    localparam int SETTLE_CYCLES  = 20;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam logic [prslr_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    typedef enum logic [1:0] {ROW_BYTE, ROW_RESTART, ROW_CFG} row_kind_t;
    typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_ONE} chk_t;

    typedef struct {
        row_kind_t                             kind;
        logic [prslr_pkg::CFG_IDX_W-1:0]       index;
        logic [prslr_pkg::CFG_DATA_W-1:0]      value;
        chk_t                                  chk;
        logic signed [prslr_pkg::SAMPLE_W-1:0] exp_left;
        logic signed [prslr_pkg::SAMPLE_W-1:0] exp_right;
    } row_t;

    typedef struct {
        logic signed [prslr_pkg::SAMPLE_W-1:0] left;
        logic signed [prslr_pkg::SAMPLE_W-1:0] right;
        logic                                  fin;
    } out_frame_t;

    logic                                  clk = 1'b0;
    logic                                  rst_n;
    logic                                  cfg_wr_en;
    logic [prslr_pkg::CFG_IDX_W-1:0]       cfg_index;
    logic [prslr_pkg::CFG_DATA_W-1:0]      cfg_data;
    logic                                  in_valid;
    logic                                  in_stall;
    logic                                  action;
    logic [7:0]                            data_byte;
    logic                                  out_valid;
    logic                                  out_stall;
    logic signed [prslr_pkg::SAMPLE_W-1:0] left_sample;
    logic signed [prslr_pkg::SAMPLE_W-1:0] right_sample;
    logic                                  last;

    // predictor state and register copies
    logic [prslr_pkg::STEP_W-1:0]          rate_step = prslr_pkg::STEP_W'(32'h10000);
    logic                                  src_stereo = 1'b1;
    logic                                  src_wide = 1'b1;
    logic [7:0]                            part_bytes [3] = '{8'h00, 8'h00, 8'h00};
    int                                    part_count = 0;
    logic signed [prslr_pkg::SAMPLE_W-1:0] prev_l = '0;
    logic signed [prslr_pkg::SAMPLE_W-1:0] prev_r = '0;
    logic                                  have_prev = 1'b0;
    logic [prslr_pkg::PHASE_W-1:0]         phase = '0;

    out_frame_t burst [$];
    out_frame_t pending [$];
    row_t       plan [$];

    int   errors = 0;
    int   frames_seen = 0;
    int   random_sent = 0;
    logic steady = 1'b0;
    logic hold_off = 1'b0;

    always #(HALF_PERIOD) clk = ~clk;

    pcm_stream_linear_resampler_core DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .action       (action),
        .data_byte    (data_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .left_sample  (left_sample),
        .right_sample (right_sample),
        .last         (last)
    );

    // prev + floor((cur - prev) * weight / 2^16)
    function automatic logic signed [prslr_pkg::SAMPLE_W-1:0] blend(
        input logic signed [prslr_pkg::SAMPLE_W-1:0] older,
        input logic signed [prslr_pkg::SAMPLE_W-1:0] newer,
        input logic [prslr_pkg::PHASE_W-1:0]         weight
    );
        longint prod;
        prod = (longint'(newer) - longint'(older)) * longint'(weight);
        return prslr_pkg::SAMPLE_W'(longint'(older) + (prod >>> 16));
    endfunction

    function automatic logic signed [prslr_pkg::SAMPLE_W-1:0] to_pcm(
        input logic [7:0] lo,
        input logic [7:0] hi
    );
        return src_wide ? {hi, lo} : {lo ^ 8'h80, 8'h00};
    endfunction

    // Advance the predictor by one transfer; output frames land in burst.
    function automatic void resample_step(input logic act, input logic [7:0] value);
        logic [7:0]                            b [4];
        int                                    frame_len;
        int                                    n;
        logic signed [prslr_pkg::SAMPLE_W-1:0] cur_l;
        logic signed [prslr_pkg::SAMPLE_W-1:0] cur_r;
        out_frame_t                            f;
        burst.delete();
        if (act == prslr_pkg::ACTION_RESTART) begin
            part_count = 0;
            have_prev  = 1'b0;
            phase      = '0;
            return;
        end
        frame_len = (src_stereo ? 2 : 1) * (src_wide ? 2 : 1);
        b[0] = part_bytes[0];
        b[1] = part_bytes[1];
        b[2] = part_bytes[2];
        b[3] = 8'h00;
        b[part_count] = value;
        if (part_count + 1 < frame_len) begin
            part_bytes[part_count] = value;
            part_count++;
            return;
        end
        part_count = 0;
        if (src_wide) begin
            cur_l = to_pcm(b[0], b[1]);
            cur_r = src_stereo ? to_pcm(b[2], b[3]) : cur_l;
        end else begin
            cur_l = to_pcm(b[0], 8'h00);
            cur_r = src_stereo ? to_pcm(b[1], 8'h00) : cur_l;
        end
        if (!have_prev) begin
            prev_l    = cur_l;
            prev_r    = cur_r;
            have_prev = 1'b1;
            return;
        end
        n = 0;
        while (phase < prslr_pkg::PHASE_ONE && n < prslr_pkg::MAX_BURST) begin
            f.left  = blend(prev_l, cur_l, phase);
            f.right = blend(prev_r, cur_r, phase);
            f.fin   = 1'b0;
            burst.push_back(f);
            n++;
            phase = prslr_pkg::PHASE_W'(phase + rate_step);
        end
        // wrap once; a phase still short of one after a full burst is kept
        if (phase >= prslr_pkg::PHASE_ONE)
            phase = phase - prslr_pkg::PHASE_ONE;
        prev_l = cur_l;
        prev_r = cur_r;
        if (n > 0) begin
            f = burst.pop_back();
            f.fin = 1'b1;
            burst.push_back(f);
        end
    endfunction

    task automatic add_row(
        input row_kind_t                        kind,
        input logic [prslr_pkg::CFG_IDX_W-1:0]  index,
        input logic [prslr_pkg::CFG_DATA_W-1:0] value,
        input chk_t                             chk,
        input int                               exp_l,
        input int                               exp_r
    );
        row_t r;
        r.kind      = kind;
        r.index     = index;
        r.value     = value;
        r.chk       = chk;
        r.exp_left  = prslr_pkg::SAMPLE_W'(exp_l);
        r.exp_right = prslr_pkg::SAMPLE_W'(exp_r);
        plan.push_back(r);
    endtask

    task automatic send_item(
        input logic                                  act,
        input logic [7:0]                            value,
        input chk_t                                  chk,
        input logic signed [prslr_pkg::SAMPLE_W-1:0] exp_l,
        input logic signed [prslr_pkg::SAMPLE_W-1:0] exp_r
    );
        out_frame_t f;
        in_valid  <= 1'b1;
        action    <= act;
        data_byte <= value;
        do @(negedge clk); while (in_stall);
        @(posedge clk);
        resample_step(act, value);
        case (chk)
            CHK_MODEL: foreach (burst[i]) pending.push_back(burst[i]);
            CHK_ONE: begin
                f.left  = exp_l;
                f.right = exp_r;
                f.fin   = 1'b1;
                pending.push_back(f);
            end
            default: ;
        endcase
        if (!steady && $urandom_range(99) < 18) begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < 18);
        end
    endtask

    // Drop valid, wait for every expected frame, then let the last burst close.
    task automatic settle();
        in_valid <= 1'b0;
        while (pending.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(
        input logic [prslr_pkg::CFG_IDX_W-1:0]  idx,
        input logic [prslr_pkg::CFG_DATA_W-1:0] value
    );
        settle();
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            prslr_pkg::CFG_PHASE_STEP:  rate_step  = value[prslr_pkg::STEP_W-1:0];
            prslr_pkg::CFG_STEREO:      src_stereo = value[0];
            prslr_pkg::CFG_SIXTEEN_BIT: src_wide   = value[0];
            default: ;
        endcase
    endtask

    task automatic build_plan();
        // reset settings: 16-bit stereo, unit step; the first frame only primes
        add_row(ROW_BYTE, '0, 8'h00, CHK_NONE, 0, 0);
        add_row(ROW_BYTE, '0, 8'h00, CHK_NONE, 0, 0);
        add_row(ROW_BYTE, '0, 8'h00, CHK_NONE, 0, 0);
        add_row(ROW_BYTE, '0, 8'h80, CHK_NONE, 0, 0);
        // zero phase reproduces the previous frame exactly
        add_row(ROW_BYTE, '0, 8'hFF, CHK_NONE, 0, 0);
        add_row(ROW_BYTE, '0, 8'h7F, CHK_NONE, 0, 0);
        add_row(ROW_BYTE, '0, 8'hFF, CHK_NONE, 0, 0);
        add_row(ROW_BYTE, '0, 8'h7F, CHK_ONE, 0, -32768);
        add_row(ROW_RESTART, '0, '0, CHK_NONE, 0, 0);
        // 8-bit mono, one-eighth step: full bursts
        add_row(ROW_CFG, prslr_pkg::CFG_PHASE_STEP, 18'd8192, CHK_MODEL, 0, 0);
        add_row(ROW_CFG, prslr_pkg::CFG_STEREO, 18'd0, CHK_MODEL, 0, 0);
        add_row(ROW_CFG, prslr_pkg::CFG_SIXTEEN_BIT, 18'd0, CHK_MODEL, 0, 0);
        add_row(ROW_BYTE, '0, 8'h00, CHK_NONE, 0, 0);
        add_row(ROW_BYTE, '0, 8'hFF, CHK_MODEL, 0, 0);
        add_row(ROW_BYTE, '0, 8'h80, CHK_MODEL, 0, 0);
        // step of three: phase stays at or above one for two frames
        add_row(ROW_CFG, prslr_pkg::CFG_PHASE_STEP, 18'd196608, CHK_MODEL, 0, 0);
        add_row(ROW_BYTE, '0, 8'h40, CHK_MODEL, 0, 0);
        add_row(ROW_BYTE, '0, 8'hC0, CHK_MODEL, 0, 0);
        add_row(ROW_BYTE, '0, 8'h10, CHK_MODEL, 0, 0);
        add_row(ROW_BYTE, '0, 8'h20, CHK_MODEL, 0, 0);
        // step too small: burst capped, leftover phase carried
        add_row(ROW_CFG, prslr_pkg::CFG_PHASE_STEP, 18'd3000, CHK_MODEL, 0, 0);
        add_row(ROW_RESTART, '0, '0, CHK_NONE, 0, 0);
        add_row(ROW_BYTE, '0, 8'h00, CHK_NONE, 0, 0);
        add_row(ROW_BYTE, '0, 8'hFF, CHK_MODEL, 0, 0);
        add_row(ROW_BYTE, '0, 8'h01, CHK_MODEL, 0, 0);
        // frame shrinks from four bytes to one after three are gathered
        add_row(ROW_CFG, prslr_pkg::CFG_STEREO, 18'd1, CHK_MODEL, 0, 0);
        add_row(ROW_CFG, prslr_pkg::CFG_SIXTEEN_BIT, 18'd1, CHK_MODEL, 0, 0);
        add_row(ROW_BYTE, '0, 8'h5A, CHK_MODEL, 0, 0);
        add_row(ROW_BYTE, '0, 8'hA5, CHK_MODEL, 0, 0);
        add_row(ROW_BYTE, '0, 8'h33, CHK_MODEL, 0, 0);
        add_row(ROW_CFG, prslr_pkg::CFG_STEREO, 18'd0, CHK_MODEL, 0, 0);
        add_row(ROW_CFG, prslr_pkg::CFG_SIXTEEN_BIT, 18'd0, CHK_MODEL, 0, 0);
        add_row(ROW_BYTE, '0, 8'hCC, CHK_MODEL, 0, 0);
    endtask

    // output side: random stall, one long hold-off on request
    initial begin
        out_stall = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_off) begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
                hold_off = 1'b0;
            end else begin
                out_stall <= !steady && ($urandom_range(99) < 18);
            end
        end
    end

    always @(negedge clk) begin
        out_frame_t want;
        if (rst_n && out_valid && !out_stall) begin
            frames_seen++;
            if (pending.size() == 0) begin
                $error("unexpected output frame: left_sample %0d right_sample %0d last %0b",
                       left_sample, right_sample, last);
                errors++;
            end else begin
                want = pending.pop_front();
                if (left_sample !== want.left) begin
                    $error("left_sample: expected %0d, actual %0d", want.left, left_sample);
                    errors++;
                end
                if (right_sample !== want.right) begin
                    $error("right_sample: expected %0d, actual %0d", want.right, right_sample);
                    errors++;
                end
                if (last !== want.fin) begin
                    $error("last: expected %0b, actual %0b", want.fin, last);
                    errors++;
                end
            end
        end
    end

    // end the run once no transfer has happened for too long
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(negedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        int                               phase_no;
        int                               burst_len;
        logic [prslr_pkg::CFG_DATA_W-1:0] step_pick;
        rst_n     = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        in_valid  = 1'b0;
        action    = prslr_pkg::ACTION_DATA;
        data_byte = 8'h00;
        build_plan();
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i]) begin
            case (plan[i].kind)
                ROW_CFG:
                    write_reg(plan[i].index, plan[i].value);
                ROW_RESTART:
                    send_item(prslr_pkg::ACTION_RESTART, 8'($urandom), plan[i].chk,
                              plan[i].exp_left, plan[i].exp_right);
                default:
                    send_item(prslr_pkg::ACTION_DATA, plan[i].value[7:0], plan[i].chk,
                              plan[i].exp_left, plan[i].exp_right);
            endcase
        end

        phase_no = 0;
        while ((random_sent < TARGET_BYTES || frames_seen < TARGET_FRAMES)
               && phase_no < MAX_PHASES) begin
            case ($urandom_range(9))
                0:       step_pick = 18'd8192;
                1:       step_pick = 18'd196608;
                2:       step_pick = 18'($urandom_range(8191));
                3:       step_pick = '1;
                default: step_pick = 18'($urandom_range(196608, 8192));
            endcase
            // keep outputs frequent while the receiver holds off
            if (phase_no == 2)
                step_pick = 18'd16384;
            write_reg(prslr_pkg::CFG_PHASE_STEP, step_pick);
            write_reg(prslr_pkg::CFG_STEREO, prslr_pkg::CFG_DATA_W'($urandom_range(1)));
            write_reg(prslr_pkg::CFG_SIXTEEN_BIT, prslr_pkg::CFG_DATA_W'($urandom_range(1)));
            if (phase_no == 0)
                write_reg(CFG_SPARE, prslr_pkg::CFG_DATA_W'($urandom));
            steady = (phase_no == 1);
            if (phase_no == 2)
                hold_off = 1'b1;
            burst_len = $urandom_range(12, 30);
            repeat (burst_len) begin
                if ($urandom_range(99) < 4)
                    send_item(prslr_pkg::ACTION_RESTART, 8'($urandom), CHK_MODEL, '0, '0);
                else
                    send_item(prslr_pkg::ACTION_DATA, 8'($urandom), CHK_MODEL, '0, '0);
                random_sent++;
            end
            phase_no++;
        end

        settle();
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
